### src/ptt_pkg.sv
// Shared types, codes and sizes for the periodic task timer table.
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

  localparam int unsigned SLOTS = 16;

  // Item kinds
  localparam logic [1:0] KindTick   = 2'd0;
  localparam logic [1:0] KindAdd    = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;

  // Result kinds
  localparam logic [1:0] ResFired   = 2'd0;
  localparam logic [1:0] ResAdded   = 2'd1;
  localparam logic [1:0] ResFull    = 2'd2;
  localparam logic [1:0] ResRemoved = 2'd3;

  // Token that walks the row of slot cells, one cell per cycle while the chain is enabled
  typedef struct packed {
    logic        active;
    logic [1:0]  kind;
    logic [3:0]  pos;       // slot index of the cell that takes it next
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [15:0] keep;      // bit 0 belongs to the cell that takes it next
    logic [15:0] now;
    logic        done;      // add already placed
    logic [4:0]  count;     // slots freed so far by a remove
  } tok_t;

  // Result as produced by a cell or by the collector
  typedef struct packed {
    logic [1:0] kind_res;
    logic [3:0] slot;
    logic [7:0] task_id_res;
    logic [4:0] removed_count;
  } res_t;

endpackage
`default_nettype wire

### src/ptt_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ptt_in_if import ptt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  task_id;
  logic [15:0] period;
  logic [15:0] keep_mask;

  modport source (output valid, kind, task_id, period, keep_mask, input ready);
  modport sink   (input valid, kind, task_id, period, keep_mask, output ready);
endinterface

interface ptt_out_if import ptt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind_res;
  logic [3:0] slot;
  logic [7:0] task_id_res;
  logic [4:0] removed_count;
  logic       last;

  modport source (output valid, kind_res, slot, task_id_res, removed_count, last,
                  input ready);
  modport sink   (input valid, kind_res, slot, task_id_res, removed_count, last,
                  output ready);
endinterface
`default_nettype wire

### src/ptt_cell.sv
// One timer slot: holds its state and acts on the token passing through.
`timescale 1ns / 1ps
`default_nettype none
module ptt_cell import ptt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  en_i,
  input  tok_t tok_i,
  output tok_t tok_o,
  output logic res_valid_o,
  output res_t res_o
);

  logic        valid_q, valid_d;
  logic [7:0]  task_q, task_d;
  logic [15:0] due_q, due_d;
  logic [15:0] period_q, period_d;
  tok_t        tok_q, tok_d;
  logic        fire, take, drop;
  logic [15:0] resched;
  logic [15:0] first_due;

  assign resched   = tok_i.now + period_q;
  assign first_due = tok_i.now + tok_i.period;

  assign fire = tok_i.active && (tok_i.kind == KindTick) && valid_q && (due_q == tok_i.now);
  assign take = tok_i.active && (tok_i.kind == KindAdd) && !tok_i.done && !valid_q;
  assign drop = tok_i.active && (tok_i.kind == KindRemove) && valid_q
                && (task_q == tok_i.task_id);

  always_comb begin
    valid_d  = valid_q;
    task_d   = task_q;
    due_d    = due_q;
    period_d = period_q;
    if (fire) begin
      if (tok_i.keep[0]) begin
        due_d = resched;
      end else begin
        valid_d = 1'b0;
      end
    end
    if (take) begin
      valid_d  = 1'b1;
      task_d   = tok_i.task_id;
      period_d = tok_i.period;
      due_d    = first_due;
    end
    if (drop) begin
      valid_d = 1'b0;
    end

    tok_d       = tok_i;
    tok_d.pos   = tok_i.pos + 4'd1;
    tok_d.keep  = {1'b0, tok_i.keep[15:1]};
    tok_d.done  = tok_i.done | take;
    tok_d.count = drop ? tok_i.count + 5'd1 : tok_i.count;
  end

  assign res_valid_o       = fire | take;
  assign res_o.kind_res    = take ? ResAdded : ResFired;
  assign res_o.slot        = tok_i.pos;
  assign res_o.task_id_res = take ? tok_i.task_id : task_q;
  assign res_o.removed_count = 5'd0;
  assign tok_o             = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Slot payload needs no reset: it is read only while the slot is valid
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      task_q   <= task_d;
      due_q    <= due_d;
      period_q <= period_d;
    end
  end

endmodule
`default_nettype wire

### src/ptt_collect.sv
// Result collector: holds one result back to mark the last, drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module ptt_collect import ptt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  res_valid_i,
  input  res_t res_i,
  input  tok_t end_tok_i,
  output logic en_o,
  output logic done_o,
  ptt_out_if.source out_o
);

  logic out_valid_q;
  res_t out_res_q;
  logic out_last_q;
  logic pend_valid_q;
  res_t pend_q;
  logic out_free;
  res_t final_res;

  assign out_free = !out_valid_q || out_o.ready;
  // Hold the chain while a result could not be placed
  assign en_o   = out_free || (!pend_valid_q && !end_tok_i.active);
  assign done_o = en_o && end_tok_i.active;

  always_comb begin
    final_res.kind_res      = (end_tok_i.kind == KindRemove) ? ResRemoved : ResFull;
    final_res.slot          = 4'd0;
    final_res.task_id_res   = end_tok_i.task_id;
    final_res.removed_count = (end_tok_i.kind == KindRemove) ? end_tok_i.count : 5'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (en_o) begin
        if (res_valid_i) begin
          pend_valid_q <= 1'b1;
          if (pend_valid_q) begin
            out_valid_q <= 1'b1;
          end
        end
        if (end_tok_i.active) begin
          case (end_tok_i.kind)
            KindTick, KindAdd: begin
              if (pend_valid_q) begin
                out_valid_q  <= 1'b1;
                pend_valid_q <= 1'b0;
              end else if (end_tok_i.kind == KindAdd) begin
                out_valid_q <= 1'b1;
              end
            end
            KindRemove: begin
              out_valid_q <= 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      if (res_valid_i) begin
        pend_q <= res_i;
        if (pend_valid_q) begin
          out_res_q  <= pend_q;
          out_last_q <= 1'b0;
        end
      end
      if (end_tok_i.active) begin
        case (end_tok_i.kind)
          KindTick, KindAdd: begin
            if (pend_valid_q) begin
              out_res_q  <= pend_q;
              out_last_q <= 1'b1;
            end else if (end_tok_i.kind == KindAdd) begin
              out_res_q  <= final_res;
              out_last_q <= 1'b1;
            end
          end
          KindRemove: begin
            out_res_q  <= final_res;
            out_last_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind_res      = out_res_q.kind_res;
  assign out_o.slot          = out_res_q.slot;
  assign out_o.task_id_res   = out_res_q.task_id_res;
  assign out_o.removed_count = out_res_q.removed_count;
  assign out_o.last          = out_last_q;

endmodule
`default_nettype wire

### src/periodic_task_timer_table.sv
// Top level of the periodic task timer table.
//
// One item is worked at a time. An accepted item is loaded into a launch
// register and walks the row of SLOTS slot cells as a token, one cell per
// cycle while the collector does not hold the row, then reaches the
// collector. Input ready returns once the collector has taken the token,
// so a new item is taken only after the last one has walked the whole row.
// A tick's fired slots come out in slot order, the last one flagged; an
// add, a full table and a remove give one result each, and an unused kind
// gives none. The last result of an item leaves the output register while
// the next item may already be walking.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_timer_table import ptt_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  ptt_in_if.sink    in_i,
  ptt_out_if.source out_o
);

  logic        busy_q;
  logic [15:0] now_q;
  tok_t        launch_q;
  tok_t        tok [SLOTS+1];
  logic [SLOTS-1:0] res_valid;
  res_t        res [SLOTS];
  logic        any_res;
  res_t        res_sel;
  logic        en;
  logic        done;
  logic        accept;
  logic [15:0] now_next;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign now_next   = (in_i.kind == KindTick) ? now_q + 16'd1 : now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      now_q    <= 16'd0;
      launch_q <= '0;
    end else begin
      if (accept) begin
        busy_q   <= 1'b1;
        now_q    <= now_next;
        launch_q <= '{active:  1'b1,
                      kind:    in_i.kind,
                      pos:     4'd0,
                      task_id: in_i.task_id,
                      period:  in_i.period,
                      keep:    in_i.keep_mask,
                      now:     now_next,
                      done:    1'b0,
                      count:   5'd0};
      end else begin
        if (en) begin
          launch_q.active <= 1'b0;
        end
        if (done) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign tok[0] = launch_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ptt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .tok_i       (tok[g]),
      .tok_o       (tok[g+1]),
      .res_valid_o (res_valid[g]),
      .res_o       (res[g])
    );
  end

  // At most one cell holds the token, so OR the masked results
  always_comb begin
    res_sel = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (res_valid[i]) begin
        res_sel = res_sel | res[i];
      end
    end
  end
  assign any_res = |res_valid;

  ptt_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (any_res),
    .res_i       (res_sel),
    .end_tok_i   (tok[SLOTS]),
    .en_o        (en),
    .done_o      (done),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

### src/ptt_checker.sv
// Port-level checks for the periodic task timer table and their bind.
`timescale 1ns / 1ps
`default_nettype none
module ptt_checker import ptt_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [1:0] out_kind_res_i,
  input wire [3:0] out_slot_i,
  input wire [7:0] out_task_id_res_i,
  input wire [4:0] out_removed_count_i,
  input wire       out_last_i
);

  // One item in flight: ready drops after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready stayed high after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable(out_kind_res_i) && $stable(out_slot_i) && $stable(out_task_id_res_i)
      && $stable(out_removed_count_i) && $stable(out_last_i))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_res_i != ResFired) |-> out_last_i)
    else $error("add or remove result not flagged last");

  a_count_only_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_res_i != ResRemoved) |-> (out_removed_count_i == 5'd0))
    else $error("removed count set on a non-remove result");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_res_i == ResFull || out_kind_res_i == ResRemoved)
      |-> (out_slot_i == 4'd0))
    else $error("slot set on a table-full or removal result");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_kind_res_i      (out_o.kind_res),
  .out_slot_i          (out_o.slot),
  .out_task_id_res_i   (out_o.task_id_res),
  .out_removed_count_i (out_o.removed_count),
  .out_last_i          (out_o.last)
);
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the periodic task timer table.
`timescale 1ns / 1ps
`default_nettype none
module testbench import ptt_pkg::*; ();

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 245;
  localparam int unsigned HoldOffStart = 120;
  localparam int unsigned HoldOffLen   = 400;
  localparam int unsigned DrainCycles  = 40;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic [15:0] keep_mask;
  } timer_item_t;

  typedef struct {
    logic [1:0] kind_res;
    logic [3:0] slot;
    logic [7:0] task_id_res;
    logic [4:0] removed_count;
    logic       last;
  } timer_res_t;

  class timer_scoreboard;
    logic [15:0] clock_now;
    bit          slot_used[SLOTS];
    logic [7:0]  slot_owner[SLOTS];
    logic [15:0] slot_deadline[SLOTS];
    logic [15:0] slot_interval[SLOTS];
    timer_res_t  awaited_results[$];
    int unsigned errors;

    function new();
      clock_now = '0;
      errors = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_owner[i] = '0;
        slot_deadline[i] = '0;
        slot_interval[i] = '0;
      end
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endfunction

    // Work out the results one accepted item causes and advance the table.
    function void note_item(timer_item_t it);
      timer_res_t  r;
      timer_res_t  fired[$];
      bit          placed;
      logic [4:0]  freed;
      r.slot = '0;
      r.removed_count = '0;
      r.last = 1'b1;
      r.task_id_res = it.task_id;
      case (it.kind)
        KindTick: begin
          clock_now = clock_now + 16'd1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_deadline[i] == clock_now) begin
              r.kind_res = ResFired;
              r.slot = 4'(i);
              r.task_id_res = slot_owner[i];
              r.last = 1'b0;
              fired.push_back(r);
              if (it.keep_mask[i]) slot_deadline[i] = clock_now + slot_interval[i];
              else slot_used[i] = 1'b0;
            end
          end
          if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
          foreach (fired[k]) awaited_results.push_back(fired[k]);
        end
        KindAdd: begin
          placed = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !slot_used[i]) begin
              placed = 1'b1;
              slot_used[i] = 1'b1;
              slot_owner[i] = it.task_id;
              slot_interval[i] = it.period;
              slot_deadline[i] = clock_now + it.period;
              r.slot = 4'(i);
            end
          end
          r.kind_res = placed ? ResAdded : ResFull;
          awaited_results.push_back(r);
        end
        KindRemove: begin
          freed = '0;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_owner[i] == it.task_id) begin
              slot_used[i] = 1'b0;
              freed = freed + 5'd1;
            end
          end
          r.kind_res = ResRemoved;
          r.removed_count = freed;
          awaited_results.push_back(r);
        end
        default: begin
          // unused kind: no change, no result
        end
      endcase
    endfunction

    function void check_result(timer_res_t got);
      timer_res_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d slot %0d task %0d",
                 $time, got.kind_res, got.slot, got.task_id_res);
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind_res !== want.kind_res) report_field("kind_res", want.kind_res, got.kind_res);
      if (got.slot !== want.slot) report_field("slot", want.slot, got.slot);
      if (got.task_id_res !== want.task_id_res)
        report_field("task_id_res", want.task_id_res, got.task_id_res);
      if (got.removed_count !== want.removed_count)
        report_field("removed_count", want.removed_count, got.removed_count);
      if (got.last !== want.last) report_field("last", want.last, got.last);
    endfunction

    function int unsigned waiting();
      return awaited_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned items_taken = 0;
  bit holding = 1'b0;
  timer_scoreboard sb;

  ptt_in_if  in_bus ();
  ptt_out_if out_bus ();

  periodic_task_timer_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk = ~clk;

  // Check results before noting the input taken at the same edge.
  always @(posedge clk) begin : monitor
    timer_res_t  got;
    timer_item_t seen;
    if (rst_n === 1'b1) begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.kind_res = out_bus.kind_res;
        got.slot = out_bus.slot;
        got.task_id_res = out_bus.task_id_res;
        got.removed_count = out_bus.removed_count;
        got.last = out_bus.last;
        sb.check_result(got);
      end
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        seen.kind = in_bus.kind;
        seen.task_id = in_bus.task_id;
        seen.period = in_bus.period;
        seen.keep_mask = in_bus.keep_mask;
        sb.note_item(seen);
        items_taken++;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side: stall in random modes, plus one long hold-off to back up the input.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && items_taken >= HoldOffStart) begin
        hold_done = 1'b1;
        holding = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
        holding = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          2: out_bus.ready <= ($urandom_range(0, 7) == 0);
          default: out_bus.ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic timer_item_t make_item(logic [1:0] kind, logic [7:0] task_id,
                                            logic [15:0] period, logic [15:0] keep_mask);
    timer_item_t it;
    it.kind = kind;
    it.task_id = task_id;
    it.period = period;
    it.keep_mask = keep_mask;
    return it;
  endfunction

  // Hold the item until the transfer edge.
  task automatic offer_item(input timer_item_t it);
    in_bus.valid <= 1'b1;
    in_bus.kind <= it.kind;
    in_bus.task_id <= it.task_id;
    in_bus.period <= it.period;
    in_bus.keep_mask <= it.keep_mask;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
  endtask

  initial begin : stimulus
    timer_item_t stim[$];
    timer_item_t it;
    int unsigned counted;
    int unsigned idx;
    int unsigned burst;
    int unsigned pick;
    sb = new();
    rst_n = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.kind <= KindTick;
    in_bus.task_id <= '0;
    in_bus.period <= '0;
    in_bus.keep_mask <= '0;

    // Directed part: empty tick, unused kind, absent removal, full table,
    // sixteen slots firing at once, removal of several slots, zero period.
    stim.push_back(make_item(KindTick, 8'h00, 16'h0000, 16'h0000));
    stim.push_back(make_item(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF));
    stim.push_back(make_item(KindRemove, 8'hFF, 16'h0000, 16'h0000));
    for (int i = 0; i < SLOTS; i++)
      stim.push_back(make_item(KindAdd, 8'h10 + 8'(i % 3), 16'd2, 16'h0000));
    stim.push_back(make_item(KindAdd, 8'hFF, 16'hFFFF, 16'hFFFF));
    stim.push_back(make_item(KindTick, 8'h00, 16'h0000, 16'hFFFF));
    stim.push_back(make_item(KindTick, 8'h00, 16'h0000, 16'hAAAA));
    stim.push_back(make_item(KindRemove, 8'h11, 16'hFFFF, 16'h0000));
    stim.push_back(make_item(KindAdd, 8'h00, 16'h0000, 16'h0000));
    stim.push_back(make_item(KindAdd, 8'h80, 16'hFFFF, 16'h0000));

    counted = 0;
    while (counted < RandomItems) begin
      pick = $urandom_range(0, 99);
      it.task_id = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
      it.period = 16'($urandom);
      it.keep_mask = 16'($urandom);
      if (pick < 55) begin
        it.kind = KindTick;
        case ($urandom_range(0, 7))
          0: it.keep_mask = 16'h0000;
          1: it.keep_mask = 16'hFFFF;
          default: ;
        endcase
      end else if (pick < 80) begin
        it.kind = KindAdd;
        case ($urandom_range(0, 9))
          0: it.period = 16'h0000;
          1, 2: ;
          default: it.period = 16'($urandom_range(1, 6));
        endcase
      end else if (pick < 95) begin
        it.kind = KindRemove;
      end else begin
        it.kind = 2'd3;
      end
      stim.push_back(it);
      counted++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    while (idx < stim.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < stim.size()) begin
        offer_item(stim[idx]);
        idx++;
        burst--;
      end
      // keep offering during the long hold-off so the block backs up
      if (!holding && $urandom_range(0, 3) != 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    in_bus.valid <= 1'b0;
    // let the monitor note the final transfer before polling the queue
    @(posedge clk);

    while (sb.waiting() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### periodic_task_timer_table.f
src/ptt_pkg.sv
src/ptt_if.sv
src/ptt_cell.sv
src/ptt_collect.sv
src/periodic_task_timer_table.sv
src/ptt_checker.sv
verif/testbench.sv
